@@ sv/ll1p_pkg.sv @@
// Package for the LL(1) parser unit: payload structs, command and status codes, back-part states.
// No dependencies.
`default_nettype none
package ll1p_pkg;
  typedef enum logic [2:0] {
    CMD_TOKEN = 3'd0,
    CMD_CELL  = 3'd1,
    CMD_RHS   = 3'd2,
    CMD_LEN   = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_MATCH    = 3'd0,
    ST_ACCEPT   = 3'd1,
    ST_NOENTRY  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_LIMIT    = 3'd5,
    ST_IDLE     = 3'd6,
    ST_LOADED   = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] token;
    logic [5:0] row_symbol;
    logic [5:0] production;
    logic       entry_valid;
    logic [2:0] rhs_position;
    logic [5:0] rhs_symbol;
    logic [3:0] rhs_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] stack_depth;
    logic [6:0] expansions;
    logic [5:0] top_symbol;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TOP,
    BK_CELL,
    BK_LEN,
    BK_PUSH,
    BK_DONE
  } bk_state_e;
endpackage
`default_nettype wire

@@ sv/ll1p_front.sv @@
// Front part of the LL(1) parser: accepts transactions into a short queue.
// Depends on ll1p_pkg.
`default_nettype none
module ll1p_front
  import ll1p_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_pop_i,
  output in_item_t      q_data_o
);
  // Two-entry queue so the back part can stall independently.
  in_item_t   mem_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ (q_pop_i && q_valid_o);
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end
endmodule
`default_nettype wire

@@ sv/ll1p_back.sv @@
// Back part of the LL(1) parser: table, production stores, stack, sequencer.
// Depends on ll1p_pkg.
`default_nettype none
module ll1p_back
  import ll1p_pkg::*;
#(
  parameter int unsigned NumSymbols     = 64,
  parameter int unsigned NumProductions = 64,
  parameter int unsigned MaxRhs         = 8,
  parameter int unsigned StackDepth     = 64,
  parameter int unsigned ExpandLimit    = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic [5:0] term_cnt_i,
  input  wire logic [5:0] start_sym_i,
  input  wire logic     q_valid_i,
  output logic          q_pop_o,
  input  wire in_item_t q_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o,
  output logic          busy_o
);
  localparam int unsigned CellN = NumSymbols * NumSymbols;
  localparam int unsigned CellW = $clog2(CellN);
  localparam int unsigned ProdW = (NumProductions > 1) ? $clog2(NumProductions) : 1;
  localparam int unsigned PosW  = (MaxRhs > 1) ? $clog2(MaxRhs) : 1;
  localparam int unsigned RhsN  = NumProductions * MaxRhs;
  localparam int unsigned RhsAW = $clog2(RhsN);
  localparam int unsigned SpW   = $clog2(StackDepth + 1);
  localparam int unsigned StkAW = $clog2(StackDepth);
  localparam int unsigned LenW  = $clog2(MaxRhs + 1);
  localparam int unsigned ExpW  = $clog2(ExpandLimit + 1);
  localparam int unsigned ClrW  = CellW + 1;

  // Memories.
  logic [ProdW-1:0] cell_mem [CellN];
  logic [5:0]       rhs_mem  [RhsN];
  logic [LenW-1:0]  len_mem  [NumProductions];
  logic [5:0]       stk_mem  [StackDepth];
  logic             cvld_mem [CellN];

  bk_state_e        st_q, st_d;
  logic [SpW-1:0]   sp_q, sp_d;
  logic             run_q, run_d;
  logic [ExpW-1:0]  cnt_q, cnt_d;
  logic [5:0]       top_q;
  logic [LenW-1:0]  plen_q, plen_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [ClrW-1:0]  clr_q;
  logic             clr_busy;
  out_item_t        out_q, out_d;
  logic             ov_q, ov_d;
  logic             cell_v_q;
  logic [ProdW-1:0] cell_p_q;
  logic [LenW-1:0]  len_rd_q;
  logic [5:0]       rhs_rd_q;

  logic [5:0]  tok;
  logic        tok_ok, top_ok, is_term;
  logic [CellW-1:0] cidx;
  logic        fin;
  logic [2:0]  fin_st;
  logic        fin_pop;
  logic        stk_we;
  logic [StkAW-1:0] stk_wa;
  logic [5:0]  stk_wd;
  logic        cmd_cell, cmd_rhs, cmd_len;

  assign tok      = q_data_i.token;
  assign clr_busy = !clr_q[ClrW-1];
  assign busy_o   = (st_q != BK_IDLE) || clr_busy;

  // Cell address uses row-major order over the symbol set.
  assign top_ok = (32'(top_q) < NumSymbols);
  assign tok_ok = (32'(tok) < NumSymbols);
  assign cidx   = CellW'(32'(top_q) * NumSymbols + 32'(tok));
  assign is_term = (top_q == 6'd0) || (top_q < term_cnt_i);

  assign cmd_cell = (st_q == BK_IDLE) && q_valid_i && !ov_q && !clr_busy &&
                    (q_data_i.command == CMD_CELL);
  assign cmd_rhs  = (st_q == BK_IDLE) && q_valid_i && !ov_q && !clr_busy &&
                    (q_data_i.command == CMD_RHS);
  assign cmd_len  = (st_q == BK_IDLE) && q_valid_i && !ov_q && !clr_busy &&
                    (q_data_i.command == CMD_LEN);

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: begin
        if (q_valid_i && !ov_q && !clr_busy &&
            q_data_i.command == CMD_TOKEN && run_q) begin
          st_d = BK_TOP;
        end
      end
      BK_TOP:  st_d = fin ? BK_DONE : BK_CELL;
      BK_CELL: st_d = fin ? BK_DONE : BK_LEN;
      BK_LEN:  st_d = fin ? BK_DONE : BK_PUSH;
      BK_PUSH: st_d = (plen_q == '0) ? BK_TOP : BK_PUSH;
      BK_DONE: st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  // Token evaluation: BK_TOP sees top_q, BK_CELL the cell, BK_LEN the length.
  always_comb begin
    fin     = 1'b0;
    fin_st  = ST_MATCH;
    fin_pop = 1'b0;
    if (st_q == BK_TOP) begin
      if (sp_q == '0) begin
        fin = 1'b1; fin_st = ST_MISMATCH;
      end else if (top_q == 6'd0 && tok == 6'd0) begin
        fin = 1'b1; fin_st = ST_ACCEPT;
      end else if (is_term) begin
        fin = 1'b1;
        if (top_q == tok) begin
          fin_st = ST_MATCH; fin_pop = 1'b1;
        end else begin
          fin_st = ST_MISMATCH;
        end
      end
    end else if (st_q == BK_CELL) begin
      if (!top_ok || !tok_ok || !cell_v_q) begin
        fin = 1'b1; fin_st = ST_NOENTRY;
      end else if (32'(cnt_q) >= ExpandLimit) begin
        fin = 1'b1; fin_st = ST_LIMIT;
      end
    end else if (st_q == BK_LEN) begin
      if (32'(sp_q) - 1 + 32'(len_rd_q) > StackDepth) begin
        fin = 1'b1; fin_st = ST_OVERFLOW;
      end
    end
  end

  // Datapath and result.
  always_comb begin
    sp_d    = sp_q;
    run_d   = run_q;
    cnt_d   = cnt_q;
    plen_d  = plen_q;
    prod_d  = prod_q;
    out_d   = out_q;
    ov_d    = ov_q && out_stall_i;
    q_pop_o = 1'b0;
    stk_we  = 1'b0;
    stk_wa  = StkAW'(sp_q);
    stk_wd  = q_data_i.rhs_symbol;
    unique case (st_q)
      BK_IDLE: begin
        cnt_d = '0;
        if (q_valid_i && !ov_q && !clr_busy) begin
          if (!(q_data_i.command == CMD_TOKEN && run_q)) begin
            q_pop_o = 1'b1;
            ov_d    = 1'b1;
            out_d.status      = ST_LOADED;
            out_d.expansions  = '0;
            if (q_data_i.command == CMD_TOKEN || q_data_i.command > CMD_RESTART) begin
              out_d.status = ST_IDLE;
            end
            out_d.stack_depth = 7'(sp_q);
            out_d.top_symbol  = (sp_q == '0) ? 6'd0 : top_q;
            if (q_data_i.command == CMD_RESTART) begin
              sp_d  = SpW'(2);
              run_d = 1'b1;
              out_d.stack_depth = 7'd2;
              out_d.top_symbol  = start_sym_i;
            end
          end
        end
      end
      BK_TOP, BK_CELL, BK_LEN: begin
        if (fin) begin
          if (fin_st != ST_MATCH) run_d = 1'b0;
          if (fin_pop) sp_d = sp_q - 1'b1;
          out_d.status      = fin_st;
          out_d.expansions  = 7'(cnt_q);
          out_d.stack_depth = 7'(fin_pop ? sp_q - 1'b1 : sp_q);
        end else if (st_q == BK_LEN) begin
          sp_d   = sp_q - 1'b1;
          plen_d = len_rd_q;
          prod_d = cell_p_q;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      BK_PUSH: begin
        if (plen_q != '0) begin
          stk_we = 1'b1;
          stk_wd = rhs_rd_q;
          sp_d   = sp_q + 1'b1;
          plen_d = plen_q - 1'b1;
        end
      end
      BK_DONE: begin
        q_pop_o = 1'b1;
        ov_d    = 1'b1;
        out_d.top_symbol = (sp_q == '0) ? 6'd0 : top_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BK_IDLE;
      sp_q  <= '0;
      run_q <= 1'b0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      clr_q <= '0;
    end else begin
      st_q  <= st_d;
      sp_q  <= sp_d;
      run_q <= run_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      if (clr_busy) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q <= plen_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  // Table memory with a clearing pass after reset.
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      cvld_mem[clr_q[CellW-1:0]] <= 1'b0;
    end else if (cmd_cell && tok_ok && (32'(q_data_i.row_symbol) < NumSymbols)) begin
      cvld_mem[CellW'(32'(q_data_i.row_symbol) * NumSymbols + 32'(tok))] <=
        q_data_i.entry_valid && (32'(q_data_i.production) < NumProductions);
      cell_mem[CellW'(32'(q_data_i.row_symbol) * NumSymbols + 32'(tok))] <=
        ProdW'(q_data_i.production);
    end
    cell_v_q <= cvld_mem[cidx];
    cell_p_q <= cell_mem[cidx];
  end

  // Length memory: read at the production registered from the table.
  always_ff @(posedge clk_i) begin
    if (cmd_len && 32'(q_data_i.production) < NumProductions) begin
      len_mem[ProdW'(q_data_i.production)] <=
        (32'(q_data_i.rhs_length) > MaxRhs) ? LenW'(MaxRhs) : LenW'(q_data_i.rhs_length);
    end
    len_rd_q <= len_mem[cell_p_q];
  end

  // Rhs memory: read symbol plen-1 of the current production, one a cycle.
  logic [LenW-1:0] rpos;
  always_comb begin
    rpos = (st_q == BK_PUSH) ? plen_d : len_rd_q;
    if (rpos != '0) rpos = rpos - 1'b1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_rhs && 32'(q_data_i.production) < NumProductions &&
        32'(q_data_i.rhs_position) < MaxRhs) begin
      rhs_mem[RhsAW'(32'(q_data_i.production) * MaxRhs + 32'(q_data_i.rhs_position))] <=
        q_data_i.rhs_symbol;
    end
    rhs_rd_q <= rhs_mem[RhsAW'(32'((st_q == BK_PUSH) ? prod_q : cell_p_q) * MaxRhs
                               + 32'(PosW'(rpos)))];
  end

  // Stack memory; the top is read into top_q every cycle.
  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && q_valid_i && !ov_q && !clr_busy &&
        q_data_i.command == CMD_RESTART) begin
      stk_mem[StkAW'(0)] <= 6'd0;
      stk_mem[StkAW'(1)] <= start_sym_i;
    end else if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
  end
  // Top register follows the top-of-stack after each update.
  always_ff @(posedge clk_i) begin
    if (st_q == BK_IDLE && q_valid_i && !ov_q && !clr_busy &&
        q_data_i.command == CMD_RESTART) begin
      top_q <= start_sym_i;
    end else if (stk_we) begin
      top_q <= stk_wd;
    end else begin
      top_q <= stk_mem[StkAW'(sp_d - 1'b1)];
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

@@ sv/ll1_table_driven_parser_unit.sv @@
// LL(1) parser top level: configuration port, front queue and back sequencer.
// Sequence: a load or restart result is valid the cycle after acceptance; a token whose
// stack top is a terminal goes from BK_TOP to BK_DONE, each expansion runs BK_TOP, BK_CELL,
// BK_LEN and BK_PUSH per rhs symbol and once more, and a table or length lookup error ends there.
// Throughput: one transaction at a time in the back part, which starts the next only after
// the previous result is taken; the front queue holds two.
// Reset: asynchronous, active low; afterwards a clearing pass empties the parse table,
// during which queued transactions wait.
`default_nettype none
module ll1_table_driven_parser_unit
  import ll1p_pkg::*;
#(
  parameter int unsigned NUM_SYMBOLS     = 64,
  parameter int unsigned NUM_PRODUCTIONS = 64,
  parameter int unsigned MAX_RHS         = 8,
  parameter int unsigned STACK_DEPTH     = 64,
  parameter int unsigned EXPAND_LIMIT    = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);
  logic [5:0] term_q, start_q;
  logic       q_valid, q_pop, busy;
  in_item_t   q_data;

  // Configuration registers; the user must write them only while the parser is idle, the block does not enforce it.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q  <= 6'd32;
      start_q <= 6'd32;
    end else if (psel && penable && pwrite) begin
      if (paddr == 3'd0) term_q  <= pwdata[5:0];
      if (paddr == 3'd4) start_q <= pwdata[5:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata[5:0] = term_q;
    if (paddr == 3'd4) prdata[5:0] = start_q;
  end

  // The front queue decouples acceptance from the sequencer.
  ll1p_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  ll1p_back #(
    .NumSymbols(NUM_SYMBOLS), .NumProductions(NUM_PRODUCTIONS), .MaxRhs(MAX_RHS),
    .StackDepth(STACK_DEPTH), .ExpandLimit(EXPAND_LIMIT)
  ) u_back (
    .clk_i, .rst_ni, .term_cnt_i(term_q), .start_sym_i(start_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o, .busy_o(busy)
  );

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  // The queue is only popped while it holds a transaction.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
  // Stack depth reported never exceeds the stack.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.stack_depth) <= STACK_DEPTH)
    else $error("stack depth out of range");
  // A pop happens only while the back part works or a transaction waits.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> busy || q_valid)
    else $error("pop without work");
endmodule
`default_nettype wire
